>>> hw/rtl/lcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcr_pkg;

  // Default display geometry
  localparam int unsigned COLUMNS_DEF = 16;
  localparam int unsigned ROWS_DEF    = 2;

  // LCD command and character codes
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_SETCUR  = 8'h80;
  localparam logic [7:0] ROW_OFFSET  = 8'h40;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [3:0] INIT_LEN    = 4'd9;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_MOVE  = 2'd2,
    ACT_CLEAR = 2'd3
  } lcr_action_e;

  // Display sequencer phase
  typedef enum logic [1:0] {
    PH_POWER   = 2'd0,
    PH_INIT    = 2'd1,
    PH_REFRESH = 2'd2,
    PH_SETCUR  = 2'd3
  } lcr_phase_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLR  = 2'd0,
    ST_IDLE = 2'd1,
    ST_READ = 2'd2
  } lcr_state_e;

  typedef struct packed {
    lcr_action_e action;
    logic [7:0]  char_code;
    logic [7:0]  target_col;
    logic [7:0]  target_row;
  } lcr_in_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;
  } lcr_out_t;

  // Byte handed to the nibble emitter
  typedef struct packed {
    logic       start;
    logic [7:0] code;
    logic       rs;
    logic       two;
  } lcr_emit_req_t;

  // Start-up command sequence
  function automatic logic [7:0] lcr_init_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd1, 4'd2: c = 8'h30;
      4'd3:             c = 8'h20;
      4'd4:             c = 8'h28;
      4'd5:             c = 8'h0C;
      4'd6:             c = 8'h06;
      4'd7:             c = 8'h01;
      default:          c = 8'h02;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/char_lcd_refresh_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-LCD controller for a 4-bit bus with a COLUMNS x ROWS frame buffer
// and a host cursor. Requests are taken one at a time. A tick that sends a
// command also passes one or two nibbles to the output; a refresh tick first
// reads the frame buffer, in the ST_READ state, and then sends its two data
// nibbles. A clear request, and the tick that ends the start-up sequence,
// sweep the frame-buffer memory one entry per cycle. After reset the same
// clearing pass runs before the first request is taken. The frame-buffer
// memory has a single write port, and one nibble emitter is shared by
// commands and frame-buffer data.
module char_lcd_refresh_controller_top
  import lcr_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lcr_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lcr_out_t      out_data
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RCW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  lcr_state_e     state_r, state_nxt;
  lcr_phase_e     phase_r, phase_nxt;
  logic [3:0]     init_idx_r, init_idx_nxt;
  logic           mode_r, mode_nxt;
  logic [RCW-1:0] ref_col_r, ref_col_nxt;
  logic           ref_row_r, ref_row_nxt;
  logic [CW-1:0]  host_col_r, host_col_nxt;
  logic           host_row_r, host_row_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  lcr_emit_req_t  emit_req;
  logic           emit_busy;
  logic           cmd_go;
  logic [7:0]     cmd_code;
  logic           accept;
  logic [AW-1:0]  host_addr;
  logic [AW-1:0]  ref_addr;

  assign in_ready = (state_r == ST_IDLE) && !emit_busy;
  assign accept   = in_valid && in_ready;

  // Row-major addresses; row is one bit so the multiply is a select
  assign host_addr = host_row_r ? AW'(COLUMNS) + AW'(host_col_r) : AW'(host_col_r);
  assign ref_addr  = ref_row_r ? AW'(COLUMNS) + AW'(ref_col_r) : AW'(ref_col_r);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    init_idx_nxt = init_idx_r;
    mode_nxt     = mode_r;
    ref_col_nxt  = ref_col_r;
    ref_row_nxt  = ref_row_r;
    host_col_nxt = host_col_r;
    host_row_nxt = host_row_r;
    clr_cnt_nxt  = clr_cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_cnt_r;
    ram_wdata    = CHAR_SPACE;
    ram_raddr    = ref_addr;
    emit_req     = '0;
    cmd_go       = 1'b0;
    cmd_code     = CMD_HOME;

    unique case (state_r)
      // Fill frame buffer with spaces, one entry per cycle
      ST_CLR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      // Frame-buffer byte is back: send it as data, advance refresh position
      ST_READ: begin
        emit_req.start = 1'b1;
        emit_req.code  = ram_rdata;
        emit_req.rs    = 1'b1;
        emit_req.two   = 1'b1;
        state_nxt      = ST_IDLE;
        if (ref_col_r == RCW'(COLUMNS - 1)) begin
          ref_col_nxt = '0;
          ref_row_nxt = (ref_row_r == 1'(ROWS - 1)) ? 1'b0 : ref_row_r + 1'b1;
          phase_nxt   = PH_SETCUR;
        end else begin
          ref_col_nxt = ref_col_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            ACT_WRITE: begin
              if (host_col_r < CW'(COLUMNS)) begin
                ram_we       = 1'b1;
                ram_waddr    = host_addr;
                ram_wdata    = in_data.char_code;
                host_col_nxt = host_col_r + 1'b1;
              end
            end
            ACT_MOVE: begin
              if (in_data.target_col < 8'(COLUMNS)) begin
                host_col_nxt = CW'(in_data.target_col);
              end
              if (in_data.target_row < 8'(ROWS)) begin
                host_row_nxt = in_data.target_row[0];
              end
            end
            ACT_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLR;
            end
            ACT_TICK: begin
              unique case (phase_r)
                PH_POWER: begin
                  init_idx_nxt = '0;
                  phase_nxt    = PH_INIT;
                end
                PH_INIT: begin
                  cmd_go = 1'b1;
                  if (init_idx_r < INIT_LEN) begin
                    cmd_code     = lcr_init_cmd(init_idx_r);
                    init_idx_nxt = init_idx_r + 1'b1;
                  end else begin
                    cmd_code    = CMD_HOME;
                    ref_col_nxt = '0;
                    ref_row_nxt = 1'b0;
                    phase_nxt   = PH_REFRESH;
                    clr_cnt_nxt = '0;
                    state_nxt   = ST_CLR;
                  end
                end
                PH_REFRESH: begin
                  state_nxt = ST_READ;
                end
                PH_SETCUR: begin
                  cmd_go    = 1'b1;
                  cmd_code  = CMD_SETCUR + (ref_row_r ? ROW_OFFSET : 8'h00) + 8'(ref_col_r);
                  phase_nxt = PH_REFRESH;
                end
                default: begin
                  phase_nxt = PH_POWER;
                end
              endcase
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Command send: low nibble only in 4-bit mode; function set enables it
    if (cmd_go) begin
      emit_req.start = 1'b1;
      emit_req.code  = cmd_code;
      emit_req.rs    = 1'b0;
      emit_req.two   = mode_r;
      if (!mode_r && (cmd_code[5:4] == 2'b10)) begin
        mode_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      phase_r    <= PH_POWER;
      init_idx_r <= '0;
      mode_r     <= 1'b0;
      ref_col_r  <= '0;
      ref_row_r  <= 1'b0;
      host_col_r <= '0;
      host_row_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      init_idx_r <= init_idx_nxt;
      mode_r     <= mode_nxt;
      ref_col_r  <= ref_col_nxt;
      ref_row_r  <= ref_row_nxt;
      host_col_r <= host_col_nxt;
      host_row_r <= host_row_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // Frame buffer
  lcr_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Nibble emitter and output register
  lcr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

// Splits one byte into high and (optionally) low nibble on the output channel
module lcr_emit
  import lcr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lcr_emit_req_t req,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lcr_out_t           out_data
);

  logic       busy_r, busy_nxt;
  logic       hi_r, hi_nxt;
  logic [7:0] code_r, code_nxt;
  logic       rs_r, rs_nxt;
  logic       two_r, two_nxt;

  // Next-nibble sequencing
  always_comb begin
    busy_nxt = busy_r;
    hi_nxt   = hi_r;
    code_nxt = code_r;
    rs_nxt   = rs_r;
    two_nxt  = two_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      hi_nxt   = 1'b1;
      code_nxt = req.code;
      rs_nxt   = req.rs;
      two_nxt  = req.two;
    end else if (busy_r && out_ready) begin
      if (hi_r && two_r) begin
        hi_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hi_r   <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
      hi_r   <= hi_nxt;
    end
    code_r <= code_nxt;
    rs_r   <= rs_nxt;
    two_r  <= two_nxt;
  end

  assign busy                = busy_r;
  assign out_valid           = busy_r;
  assign out_data.nibble     = hi_r ? code_r[7:4] : code_r[3:0];
  assign out_data.reg_select = rs_r;
  assign out_data.last       = hi_r ? !two_r : 1'b1;

endmodule

`default_nettype wire

>>> bench/tb_char_lcd_refresh_controller_top.sv
`timescale 1ns / 1ps

module tb_char_lcd_refresh_controller_top;
  import lcr_pkg::*;

  localparam int COLS   = COLUMNS_DEF;
  localparam int ROWS_N = ROWS_DEF;
  localparam int CELLS  = COLS * ROWS_N;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int QUIET_FROM      = 1500;
  localparam int MAX_REPORTS     = 20;

  // Start-up command bytes, in the order the display expects them
  localparam logic [7:0] START_CMDS [9] = '{
    8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h02
  };

  // One request plus, where it is obvious, the nibbles it must produce
  typedef struct {
    lcr_in_t  req;
    int       n_typed;   // -1: take the nibbles from the display model
    lcr_out_t res [2];
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lcr_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b1;
  lcr_out_t out_data;

  bit        idle_en;
  int        mismatches;
  int        nibbles_checked;
  int        requests_by_action [4];
  stim_row_t directed_rows [$];
  lcr_out_t  expected_nibbles [$];

  // Display model state
  lcr_phase_e seq_phase;
  logic [3:0] init_pos;
  logic       four_bit;
  int         ref_col;
  logic       ref_row;
  logic [4:0] cur_col;
  logic       cur_row;
  logic [7:0] frame_buf [CELLS];
  lcr_out_t   pred_nibs [2];

  char_lcd_refresh_controller_top #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void blank_frame();
    for (int k = 0; k < CELLS; k++) begin
      frame_buf[k] = CHAR_SPACE;
    end
  endfunction

  // Command byte: high nibble always; low nibble only once the bus is 4-bit
  function automatic int emit_command(logic [7:0] c);
    int n;
    n = 0;
    pred_nibs[n] = '{c[7:4], 1'b0, 1'b0};
    n++;
    if (four_bit) begin
      pred_nibs[n] = '{c[3:0], 1'b0, 1'b0};
      n++;
    end else if (c[5:4] == 2'b10) begin
      four_bit = 1'b1;
    end
    pred_nibs[n-1].last = 1'b1;
    return n;
  endfunction

  // Advance the display model by one request; returns the nibble count
  function automatic int lcd_predict(lcr_in_t r);
    int n;
    logic [7:0] ch;
    n = 0;
    case (r.action)
      ACT_WRITE: begin
        // past the end of a row the character is dropped
        if (cur_col < COLS && cur_row < ROWS_N) begin
          frame_buf[int'(cur_row) * COLS + int'(cur_col)] = r.char_code;
          cur_col = cur_col + 5'd1;
        end
      end
      ACT_MOVE: begin
        if (r.target_col < COLS) cur_col = r.target_col[4:0];
        if (r.target_row < ROWS_N) cur_row = r.target_row[0];
      end
      ACT_CLEAR: blank_frame();
      default: begin
        case (seq_phase)
          PH_POWER: begin
            init_pos  = '0;
            seq_phase = PH_INIT;
          end
          PH_INIT: begin
            if (init_pos < INIT_LEN) begin
              n = emit_command(START_CMDS[init_pos]);
              init_pos = init_pos + 4'd1;
            end else begin
              n = emit_command(CMD_HOME);
              blank_frame();
              ref_col   = 0;
              ref_row   = 1'b0;
              seq_phase = PH_REFRESH;
            end
          end
          PH_REFRESH: begin
            ch = frame_buf[int'(ref_row) * COLS + ref_col];
            pred_nibs[0] = '{ch[7:4], 1'b1, 1'b0};
            pred_nibs[1] = '{ch[3:0], 1'b1, 1'b1};
            n = 2;
            ref_col++;
            if (ref_col >= COLS) begin
              ref_col   = 0;
              ref_row   = (int'(ref_row) + 1 >= ROWS_N) ? 1'b0 : 1'b1;
              seq_phase = PH_SETCUR;
            end
          end
          PH_SETCUR: begin
            n = emit_command(CMD_SETCUR + (ref_row ? ROW_OFFSET : 8'h00)
                             + 8'(ref_col));
            seq_phase = PH_REFRESH;
          end
        endcase
      end
    endcase
    return n;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Directed row; rs applies to both nibbles, last marks the final one
  task automatic add_row(lcr_action_e a, logic [7:0] ch, logic [7:0] col,
                         logic [7:0] row, int n, logic rs,
                         logic [3:0] n0, logic [3:0] n1);
    stim_row_t d;
    d.req     = '{a, ch, col, row};
    d.n_typed = n;
    d.res[0]  = '{n0, rs, (n == 1)};
    d.res[1]  = '{n1, rs, 1'b1};
    directed_rows.push_back(d);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t d;
    int pick;
    d.n_typed         = -1;
    d.res[0]          = '0;
    d.res[1]          = '0;
    d.req.char_code   = 8'($urandom);
    d.req.target_col  = 8'($urandom);
    d.req.target_row  = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      d.req.action = ACT_TICK;
    end else if (pick < 76) begin
      d.req.action = ACT_WRITE;
    end else if (pick < 94) begin
      // mostly legal coordinates, now and then an out-of-range one
      d.req.action = ACT_MOVE;
      if ($urandom_range(0, 4) != 0) d.req.target_col = 8'($urandom_range(0, COLS - 1));
      if ($urandom_range(0, 4) != 0) d.req.target_row = 8'($urandom_range(0, ROWS_N - 1));
    end else begin
      d.req.action = ACT_CLEAR;
    end
    return d;
  endfunction

  // Drop valid between requests
  task automatic sender_pause(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one request, wait for the handshake, then queue its nibbles
  task automatic send_row(stim_row_t d);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d.req;
    do @(posedge clk); while (!in_ready);
    requests_by_action[d.req.action]++;
    n = lcd_predict(d.req);
    if (d.n_typed >= 0) begin
      for (int k = 0; k < d.n_typed; k++) expected_nibbles.push_back(d.res[k]);
    end else begin
      for (int k = 0; k < n; k++) expected_nibbles.push_back(pred_nibs[k]);
    end
  endtask

  // Result side: random stall bursts on out_ready while idling is enabled
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted nibble with the oldest expectation
  always @(posedge clk) begin
    lcr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      nibbles_checked++;
      if (expected_nibbles.size() == 0) begin
        report_mismatch($sformatf("unexpected nibble %h rs=%0b last=%0b",
                                  out_data.nibble, out_data.reg_select, out_data.last));
      end else begin
        want = expected_nibbles.pop_front();
        if (out_data.nibble !== want.nibble)
          report_mismatch($sformatf("nibble %h, expected %h", out_data.nibble, want.nibble));
        if (out_data.reg_select !== want.reg_select)
          report_mismatch($sformatf("reg_select %0b, expected %0b",
                                    out_data.reg_select, want.reg_select));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_data.last, want.last));
      end
    end
  end

  initial begin
    stim_row_t d;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    idle_en         = 1'b1;
    mismatches      = 0;
    nibbles_checked = 0;
    foreach (requests_by_action[k]) requests_by_action[k] = 0;

    seq_phase = PH_POWER;
    init_pos  = '0;
    four_bit  = 1'b0;
    ref_col   = 0;
    ref_row   = 1'b0;
    cur_col   = '0;
    cur_row   = 1'b0;
    blank_frame();

    // power-up, start-up sequence, home, then cursor and buffer corners
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  1, 1'b0, 4'h3, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  1, 1'b0, 4'h3, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  1, 1'b0, 4'h3, 4'h0);
    add_row(ACT_WRITE, 8'h7E, 8'h00, 8'h00, -1, 1'b0, 4'h0, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  1, 1'b0, 4'h2, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b0, 4'h2, 4'h8);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b0, 4'h0, 4'hC);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b0, 4'h0, 4'h6);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b0, 4'h0, 4'h1);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b0, 4'h0, 4'h2);
    add_row(ACT_TICK,  8'hFF, 8'hFF, 8'hFF,  2, 1'b0, 4'h0, 4'h2);
    add_row(ACT_MOVE,  8'h00, 8'h0F, 8'h01,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_WRITE, 8'hFF, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_WRITE, 8'h00, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_MOVE,  8'h00, 8'hFF, 8'hFF,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_MOVE,  8'h00, 8'h00, 8'hFF,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_WRITE, 8'h00, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_MOVE,  8'h00, 8'h10, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_WRITE, 8'hA5, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b1, 4'h2, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00, -1, 1'b0, 4'h0, 4'h0);
    add_row(ACT_CLEAR, 8'h00, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00,  2, 1'b1, 4'h2, 4'h0);
    add_row(ACT_WRITE, 8'h5A, 8'h00, 8'h00,  0, 1'b0, 4'h0, 4'h0);
    add_row(ACT_TICK,  8'h00, 8'h00, 8'h00, -1, 1'b0, 4'h0, 4'h0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if ($urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 12));
      send_row(directed_rows[k]);
    end

    // random traffic; idling is switched per block of requests, off at the end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) idle_en = (i < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (idle_en && $urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 12));
      d = random_row();
      send_row(d);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    idle_en = 1'b0;
    while (expected_nibbles.size() != 0) @(posedge clk);
    repeat (CELLS + 16) @(posedge clk);

    $display("Sent %0d ticks, %0d writes, %0d moves and %0d clears",
             requests_by_action[ACT_TICK], requests_by_action[ACT_WRITE],
             requests_by_action[ACT_MOVE], requests_by_action[ACT_CLEAR]);
    $display("Compared %0d nibbles; %0d mismatches", nibbles_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
